### sv/pdc_pkg.sv
package pdc_pkg;

   // request codes
   localparam logic [1:0] REQ_KEY     = 2'd0;
   localparam logic [1:0] REQ_TEXT    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   localparam int unsigned CELLS  = 25;
   localparam int unsigned IDX_AW = 5;

   // letter index of X in the 25-letter alphabet
   localparam logic [4:0] LETTER_X   = 5'd22;
   localparam logic [4:0] LETTER_I   = 5'd8;
   localparam logic [4:0] LETTER_J   = 5'd9;
   localparam logic [4:0] LAST_INDEX = 5'd24;
   localparam logic [4:0] FULL_COUNT = 5'd25;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] ASCII_CASE    = 8'h20;

   // register word index
   localparam logic CSR_DECRYPT_MODE = 1'b0;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
      logic       message_end;
   } req_beat_type;

   typedef struct packed {
      logic [6:0] out_letter;
      logic       run_last;
   } rsp_beat_type;

endpackage

### sv/pdc_ram.sv
module pdc_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/playfair_digram_cipher_core.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_beat_type (req_type, data_byte, message_end)
// rsp       out        rsp_valid / rsp_stall  rsp_beat_type (out_letter, run_last)
// csr       in         psel/penable/pwrite    decrypt_mode at word 0, pready always high
//
// key byte and restart are done in ST_IDLE; a text byte passes ST_RDA through ST_EMIT1 once
// per digram it closes (at most two), as one square and one position read port serve every
// lookup. the first text byte after reset or restart adds a walk to finish the square.
// each emitted letter waits in its state while rsp_stall holds the output register.
// synchronous active-high reset clears the square bookkeeping and the message state.
module playfair_digram_cipher_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pdc_pkg::req_beat_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pdc_pkg::rsp_beat_type rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   import pdc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_RDA   = 3'd2;
   localparam logic [2:0] ST_RDB   = 3'd3;
   localparam logic [2:0] ST_ADDR0 = 3'd4;
   localparam logic [2:0] ST_EMIT0 = 3'd5;
   localparam logic [2:0] ST_RD1   = 3'd6;
   localparam logic [2:0] ST_EMIT1 = 3'd7;

   function automatic logic [5:0] letter_lookup(input logic [7:0] b);
      logic [7:0] up;
      logic [4:0] u;
      logic       ok;
      up = (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) ? (b - ASCII_CASE) : b;
      ok = (up >= ASCII_UPPER_A) && (up <= ASCII_UPPER_Z);
      u  = 5'(up - ASCII_UPPER_A);
      if (u == LETTER_J) begin
         u = LETTER_I;
      end else if (u > LETTER_J) begin
         u = u - 5'd1;
      end
      return {ok, u};
   endfunction

   function automatic logic [2:0] cell_row(input logic [4:0] p);
      logic [2:0] r;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
      return 5'({r, 2'b00}) + 5'(r) + 5'(c);
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] p, input logic [2:0] r);
      return 3'(p - cell_addr(r, 3'd0));
   endfunction

   function automatic logic [2:0] step5(input logic [2:0] c, input logic dec);
      logic [2:0] s;
      if (dec) begin
         s = (c == 3'd0) ? 3'd4 : c - 3'd1;
      end else begin
         s = (c == 3'd4) ? 3'd0 : c + 3'd1;
      end
      return s;
   endfunction

   logic [2:0]   state_ff, state_in;
   logic         decrypt_mode_ff, decrypt_mode_in;
   logic [24:0]  letter_used_ff, letter_used_in;
   logic [4:0]   fill_ff, fill_in;
   logic         square_ready_ff, square_ready_in;
   logic [4:0]   held_letter_ff, held_letter_in;
   logic         held_valid_ff, held_valid_in;
   logic [4:0]   prev_letter_ff, prev_letter_in;
   logic         prev_valid_ff, prev_valid_in;
   logic [4:0]   walk_idx_ff, walk_idx_in;
   logic [4:0]   pair0_a_ff, pair0_a_in, pair0_b_ff, pair0_b_in;
   logic [4:0]   pair1_a_ff, pair1_a_in, pair1_b_ff, pair1_b_in;
   logic [1:0]   pair_cnt_ff, pair_cnt_in;
   logic         pair_sel_ff, pair_sel_in;
   logic [4:0]   pa_ff, pa_in;
   logic [4:0]   addr0_ff, addr0_in, addr1_ff, addr1_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_payload_ff, rsp_payload_in;

   logic       req_accept;
   logic       csr_write;
   logic [5:0] lookup;
   logic       li_valid;
   logic [4:0] li;
   logic       out_free;
   logic [4:0] cur_a, cur_b;
   logic [2:0] ra, ca, rb, cb;
   logic [4:0] pb;
   logic [4:0] calc_addr0, calc_addr1;
   logic [6:0] letter_ascii;

   logic       wr_en;
   logic [4:0] wr_letter;
   logic [4:0] pos_raddr, pos_rdata;
   logic [4:0] sq_raddr, sq_rdata;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = psel && penable && pwrite && pready;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == CSR_DECRYPT_MODE) ? {31'd0, decrypt_mode_ff} : 32'd0;

   assign lookup   = letter_lookup(req_payload.data_byte);
   assign li_valid = lookup[5];
   assign li       = lookup[4:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign cur_a = pair_sel_ff ? pair1_a_ff : pair0_a_ff;
   assign cur_b = pair_sel_ff ? pair1_b_ff : pair0_b_ff;

   // row, column or rectangle lookup from the two positions
   assign pb = pos_rdata;
   assign ra = cell_row(pa_ff);
   assign ca = cell_col(pa_ff, ra);
   assign rb = cell_row(pb);
   assign cb = cell_col(pb, rb);

   always_comb begin
      if (ra == rb) begin
         calc_addr0 = cell_addr(ra, step5(ca, decrypt_mode_ff));
         calc_addr1 = cell_addr(rb, step5(cb, decrypt_mode_ff));
      end else if (ca == cb) begin
         calc_addr0 = cell_addr(step5(ra, decrypt_mode_ff), ca);
         calc_addr1 = cell_addr(step5(rb, decrypt_mode_ff), cb);
      end else begin
         calc_addr0 = cell_addr(ra, cb);
         calc_addr1 = cell_addr(rb, ca);
      end
   end

   // index to ascii, skipping J
   assign letter_ascii = 7'(ASCII_UPPER_A) + {2'b00, sq_rdata} + {6'd0, (sq_rdata >= LETTER_J)};

   always_comb begin
      logic       ins;
      logic       hv;
      logic [4:0] hl;
      logic [1:0] cnt;
      logic [4:0] p0a, p0b, p1a, p1b;

      state_in        = state_ff;
      decrypt_mode_in = decrypt_mode_ff;
      letter_used_in  = letter_used_ff;
      fill_in         = fill_ff;
      square_ready_in = square_ready_ff;
      held_letter_in  = held_letter_ff;
      held_valid_in   = held_valid_ff;
      prev_letter_in  = prev_letter_ff;
      prev_valid_in   = prev_valid_ff;
      walk_idx_in     = walk_idx_ff;
      pair0_a_in      = pair0_a_ff;
      pair0_b_in      = pair0_b_ff;
      pair1_a_in      = pair1_a_ff;
      pair1_b_in      = pair1_b_ff;
      pair_cnt_in     = pair_cnt_ff;
      pair_sel_in     = pair_sel_ff;
      pa_in           = pa_ff;
      addr0_in        = addr0_ff;
      addr1_in        = addr1_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_payload_in  = rsp_payload_ff;
      wr_en           = 1'b0;
      wr_letter       = li;
      pos_raddr       = cur_a;
      sq_raddr        = addr0_ff;

      ins = 1'b0;
      hv  = held_valid_ff;
      hl  = held_letter_ff;
      cnt = 2'd0;
      p0a = pair0_a_ff;
      p0b = pair0_b_ff;
      p1a = pair1_a_ff;
      p1b = pair1_b_ff;

      if (csr_write && paddr[2] == CSR_DECRYPT_MODE) begin
         decrypt_mode_in = pwdata[0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_payload.req_type)
                  REQ_KEY: begin
                     if (!square_ready_ff && li_valid && !letter_used_ff[li] &&
                         fill_ff < FULL_COUNT) begin
                        wr_en              = 1'b1;
                        letter_used_in[li] = 1'b1;
                        fill_in            = fill_ff + 5'd1;
                     end
                  end
                  REQ_TEXT: begin
                     // plan every digram this byte closes
                     ins = li_valid && !decrypt_mode_ff && prev_valid_ff &&
                           (prev_letter_ff == li);
                     if (ins) begin
                        if (hv) begin
                           p0a = hl;
                           p0b = LETTER_X;
                           cnt = 2'd1;
                           hv  = 1'b0;
                        end else begin
                           hl = LETTER_X;
                           hv = 1'b1;
                        end
                     end
                     if (li_valid) begin
                        if (hv) begin
                           if (cnt == 2'd0) begin
                              p0a = hl;
                              p0b = li;
                           end else begin
                              p1a = hl;
                              p1b = li;
                           end
                           cnt = cnt + 2'd1;
                           hv  = 1'b0;
                        end else begin
                           hl = li;
                           hv = 1'b1;
                        end
                        prev_letter_in = li;
                        prev_valid_in  = 1'b1;
                     end
                     if (req_payload.message_end) begin
                        if (hv) begin
                           if (cnt == 2'd0) begin
                              p0a = hl;
                              p0b = LETTER_X;
                           end else begin
                              p1a = hl;
                              p1b = LETTER_X;
                           end
                           cnt = cnt + 2'd1;
                        end
                        hv             = 1'b0;
                        hl             = 5'd0;
                        prev_letter_in = 5'd0;
                        prev_valid_in  = 1'b0;
                     end
                     held_valid_in  = hv;
                     held_letter_in = hl;
                     pair0_a_in     = p0a;
                     pair0_b_in     = p0b;
                     pair1_a_in     = p1a;
                     pair1_b_in     = p1b;
                     pair_cnt_in    = cnt;
                     pair_sel_in    = 1'b0;
                     walk_idx_in    = 5'd0;
                     if (!square_ready_ff) begin
                        state_in = ST_WALK;
                     end else if (cnt != 2'd0) begin
                        state_in = ST_RDA;
                     end
                  end
                  REQ_RESTART: begin
                     letter_used_in  = '0;
                     fill_in         = 5'd0;
                     square_ready_in = 1'b0;
                     held_letter_in  = 5'd0;
                     held_valid_in   = 1'b0;
                     prev_letter_in  = 5'd0;
                     prev_valid_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            wr_letter = walk_idx_ff;
            if (!letter_used_ff[walk_idx_ff]) begin
               wr_en                       = 1'b1;
               letter_used_in[walk_idx_ff] = 1'b1;
               fill_in                     = fill_ff + 5'd1;
            end
            walk_idx_in = walk_idx_ff + 5'd1;
            if (walk_idx_ff == LAST_INDEX) begin
               square_ready_in = 1'b1;
               state_in        = (pair_cnt_ff != 2'd0) ? ST_RDA : ST_IDLE;
            end
         end
         ST_RDA: begin
            pos_raddr = cur_a;
            state_in  = ST_RDB;
         end
         ST_RDB: begin
            pos_raddr = cur_b;
            pa_in     = pos_rdata;
            state_in  = ST_ADDR0;
         end
         ST_ADDR0: begin
            sq_raddr = calc_addr0;
            addr0_in = calc_addr0;
            addr1_in = calc_addr1;
            state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            sq_raddr = addr0_ff;
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.out_letter = letter_ascii;
               rsp_payload_in.run_last   = 1'b0;
               state_in                  = ST_RD1;
            end
         end
         ST_RD1: begin
            sq_raddr = addr1_ff;
            state_in = ST_EMIT1;
         end
         ST_EMIT1: begin
            sq_raddr = addr1_ff;
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.out_letter = letter_ascii;
               rsp_payload_in.run_last   = pair_sel_ff || (pair_cnt_ff == 2'd1);
               if (!pair_sel_ff && pair_cnt_ff == 2'd2) begin
                  pair_sel_in = 1'b1;
                  state_in    = ST_RDA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         decrypt_mode_ff <= 1'b0;
         letter_used_ff  <= '0;
         fill_ff         <= 5'd0;
         square_ready_ff <= 1'b0;
         held_letter_ff  <= 5'd0;
         held_valid_ff   <= 1'b0;
         prev_letter_ff  <= 5'd0;
         prev_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pair_cnt_ff     <= 2'd0;
         pair_sel_ff     <= 1'b0;
         walk_idx_ff     <= 5'd0;
      end else begin
         state_ff        <= state_in;
         decrypt_mode_ff <= decrypt_mode_in;
         letter_used_ff  <= letter_used_in;
         fill_ff         <= fill_in;
         square_ready_ff <= square_ready_in;
         held_letter_ff  <= held_letter_in;
         held_valid_ff   <= held_valid_in;
         prev_letter_ff  <= prev_letter_in;
         prev_valid_ff   <= prev_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pair_cnt_ff     <= pair_cnt_in;
         pair_sel_ff     <= pair_sel_in;
         walk_idx_ff     <= walk_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pair0_a_ff     <= pair0_a_in;
      pair0_b_ff     <= pair0_b_in;
      pair1_a_ff     <= pair1_a_in;
      pair1_b_ff     <= pair1_b_in;
      pa_ff          <= pa_in;
      addr0_ff       <= addr0_in;
      addr1_ff       <= addr1_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // square: cell -> letter
   pdc_ram #(
      .WIDTH(IDX_AW),
      .DEPTH(CELLS)
   ) u_square_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff),
      .wr_data(wr_letter),
      .rd_addr(sq_raddr),
      .rd_data(sq_rdata)
   );

   // inverse: letter -> cell
   pdc_ram #(
      .WIDTH(IDX_AW),
      .DEPTH(CELLS)
   ) u_position_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_letter),
      .wr_data(fill_ff),
      .rd_addr(pos_raddr),
      .rd_data(pos_rdata)
   );

   a_used_matches_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(letter_used_ff) == 32'(fill_ff))
      else $error("letter_used count differs from fill count");

   a_lookup_needs_full_square: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDA) |-> (square_ready_ff && fill_ff == FULL_COUNT))
      else $error("digram lookup before square complete");

   a_walk_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && walk_idx_ff == LAST_INDEX) |=> square_ready_ff)
      else $error("square not ready after walk");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.out_letter >= 7'h41 &&
                        rsp_payload_ff.out_letter <= 7'h5A &&
                        rsp_payload_ff.out_letter != 7'h4A))
      else $error("result letter out of range");

   a_pair_select: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT1 && pair_sel_ff) |-> (pair_cnt_ff == 2'd2))
      else $error("second digram selected without a second digram");

endmodule
